/* src/rrq_pkg.sv */
// ----------------------------------------------------------------------------
// rrq_pkg
// shared constants and types for the report ring queue
// ----------------------------------------------------------------------------
package rrq_pkg;

   localparam int STAMP_W = 32;
   localparam int HELD_W  = 5;

   // operation codes on req_operation
   localparam logic OP_NEW    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [HELD_W-1:0] HELD_MAX = 5'd31;

   // flags and count of one step, passed from the pointer control to the top
   typedef struct packed {
      logic              overflow_dropped;
      logic              underflow;
      logic              oldest_ok;
      logic              current_ok;
      logic [HELD_W-1:0] held_count;
   } step_type;

endpackage

/* src/report_ring_queue_drop_oldest_unit.sv */
// ----------------------------------------------------------------------------
// report_ring_queue_drop_oldest_unit
// ring queue of report stamps that drops the oldest report when full
// ----------------------------------------------------------------------------
//  channel | direction | word
//  req_    | in        | operation, stamp
//  rsp_    | out       | oldest and current report, flags, held count
//
//  one word per cycle while req_ready is high; a result passes through the
//  registered read of the stamp memory and then the output register.
//  reset clears the pointers and the current flag; memory is not cleared.
//  a stalled result holds the read stage, and req_ready drops while both the
//  read stage and the output register are full and rsp_ready is low.
// ----------------------------------------------------------------------------
module report_ring_queue_drop_oldest_unit
   import rrq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [STAMP_W-1:0] req_stamp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_oldest_valid,
   output logic [STAMP_W-1:0] rsp_oldest_stamp,
   output logic               rsp_current_ok,
   output logic [STAMP_W-1:0] rsp_current_stamp,
   output logic               rsp_overflow_dropped,
   output logic               rsp_underflow,
   output logic [HELD_W-1:0]  rsp_held_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic               accept;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [STAMP_W-1:0] rd_data;
   step_type           step;
   logic [STAMP_W-1:0] cur_stamp;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_move;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               oldest_valid_ff;
   logic [STAMP_W-1:0] oldest_stamp_ff;
   logic               current_ok_ff;
   logic [STAMP_W-1:0] current_stamp_ff;
   logic               overflow_ff;
   logic               underflow_ff;
   logic [HELD_W-1:0]  held_ff;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   rrq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .stamp     (req_stamp),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .step      (step),
      .cur_stamp (cur_stamp)
   );

   rrq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_stamp),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         oldest_valid_ff  <= step.oldest_ok;
         oldest_stamp_ff  <= step.oldest_ok ? rd_data : '0;
         current_ok_ff    <= step.current_ok;
         current_stamp_ff <= step.current_ok ? cur_stamp : '0;
         overflow_ff      <= step.overflow_dropped;
         underflow_ff     <= step.underflow;
         held_ff          <= step.held_count;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_oldest_valid     = oldest_valid_ff;
   assign rsp_oldest_stamp     = oldest_stamp_ff;
   assign rsp_current_ok       = current_ok_ff;
   assign rsp_current_stamp    = current_stamp_ff;
   assign rsp_overflow_dropped = overflow_ff;
   assign rsp_underflow        = underflow_ff;
   assign rsp_held_count       = held_ff;

endmodule

/* src/rrq_store.sv */
// ----------------------------------------------------------------------------
// rrq_store
// stamp memory, one write and one registered read port, write data forwarded
// ----------------------------------------------------------------------------
module rrq_store
   import rrq_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [STAMP_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [STAMP_W-1:0] rd_data
);

   logic [STAMP_W-1:0] mem [DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // a read of the entry written in the same cycle returns the new word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rrq_ctrl.sv */
// ----------------------------------------------------------------------------
// rrq_ctrl
// insert, remove and current slot pointers; computes the memory accesses
// and the flags of each accepted word
// ----------------------------------------------------------------------------
module rrq_ctrl
   import rrq_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               operation,
   input  logic [STAMP_W-1:0] stamp,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [AW-1:0]      rd_addr,
   output step_type           step,
   output logic [STAMP_W-1:0] cur_stamp
);

   localparam int CW = AW + 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [AW-1:0]      ins_ff, ins_in;
   logic [AW-1:0]      rem_ff, rem_in;
   logic [AW-1:0]      cur_slot_ff, cur_slot_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [STAMP_W-1:0] cur_stamp_ff;
   step_type           step_ff, step_in;

   logic [AW-1:0] ins_nxt;
   logic [AW-1:0] rem_nxt;
   logic          is_new;
   logic          full;
   logic          empty;
   logic [CW-1:0] diff;
   logic [CW-1:0] cnt;

   assign ins_nxt = (ins_ff == LAST) ? '0 : ins_ff + AW'(1);
   assign rem_nxt = (rem_ff == LAST) ? '0 : rem_ff + AW'(1);
   assign is_new  = (operation == OP_NEW);
   assign full    = (ins_nxt == rem_ff);
   assign empty   = (ins_ff == rem_ff);

   always_comb begin
      ins_in       = ins_ff;
      rem_in       = rem_ff;
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = '0;
      if (is_new) begin
         if (full) begin
            step_in.overflow_dropped = 1'b1;
            rem_in = rem_nxt;
         end
         cur_slot_in  = ins_ff;
         cur_valid_in = 1'b1;
         ins_in       = ins_nxt;
      end else if (empty) begin
         step_in.underflow = 1'b1;
      end else begin
         if (cur_valid_ff && (cur_slot_ff == rem_ff)) begin
            cur_valid_in = 1'b0;
         end
         rem_in = rem_nxt;
      end
      step_in.oldest_ok  = (rem_in != ins_in);
      step_in.current_ok = cur_valid_in;
      step_in.held_count = (32'(cnt) > 32'(HELD_MAX)) ? HELD_MAX : HELD_W'(cnt);
   end

   // held count after the step, with wrap for any depth
   always_comb begin
      diff = {1'b0, ins_in} - {1'b0, rem_in};
      if (ins_in < rem_in) begin
         cnt = diff + CW'(DEPTH);
      end else begin
         cnt = diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff       <= '0;
         rem_ff       <= '0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
      end else if (accept) begin
         ins_ff       <= ins_in;
         rem_ff       <= rem_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
      end
   end

   // the current report is always the last one written
   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff <= step_in;
         if (is_new) begin
            cur_stamp_ff <= stamp;
         end
      end
   end

   assign wr_en     = accept && is_new;
   assign wr_addr   = ins_ff;
   assign rd_addr   = rem_in;
   assign step      = step_ff;
   assign cur_stamp = cur_stamp_ff;

endmodule
